### sv/tower_lamp_blink_monitor_modbus_defines.svh
// assertion macros shared by the tower lamp monitor rtl
`ifndef TOWER_LAMP_BLINK_MONITOR_MODBUS_DEFINES_SVH
`define TOWER_LAMP_BLINK_MONITOR_MODBUS_DEFINES_SVH

// same-cycle implication, clocked on clk_i, off during reset
`define TLBM_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("tlbm: same-cycle check failed");

// next-cycle implication, clocked on clk_i, off during reset
`define TLBM_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("tlbm: next-cycle check failed");

`endif

### sv/tlbm_pkg.sv
// shared types, constants and crc function of the tower lamp monitor
package tlbm_pkg;

  // request buffer geometry
  localparam int ReqLen   = 6;
  localparam int ReqIdxW  = $clog2(ReqLen);
  localparam int ReqSteps = ReqLen - 2;
  localparam int StepW    = (ReqSteps > 1) ? $clog2(ReqSteps) : 1;

  // reply frame layout
  localparam int ReplyLen    = 15;
  localparam int ReplyIdxW   = $clog2(ReplyLen);
  localparam int ReplyCrcPos = ReplyLen - 2;

  localparam logic [15:0] CrcPoly   = 16'hA001;
  localparam logic [15:0] CrcInit   = 16'hFFFF;
  localparam logic [7:0]  FuncCode  = 8'h04;
  localparam logic [7:0]  ByteCount = 8'h0A;

  // command queue between front and back
  localparam int QDepth = 2;
  localparam int QPtrW  = (QDepth > 1) ? $clog2(QDepth) : 1;
  localparam int QCntW  = $clog2(QDepth + 1);

  // configuration register indexes
  localparam logic [1:0] CfgDevAddr   = 2'd0;
  localparam logic [1:0] CfgThreshold = 2'd1;
  localparam logic [1:0] CfgWindow    = 2'd2;
  localparam logic [1:0] CfgKind      = 2'd3;

  typedef enum logic [1:0] {
    ColNone   = 2'd0,
    ColRed    = 2'd1,
    ColYellow = 2'd2,
    ColGreen  = 2'd3
  } colour_e;

  typedef struct packed {
    logic [7:0]  dev_addr;
    logic [11:0] threshold;
    logic [15:0] window;
    logic [7:0]  kind;
  } cfg_t;

  // one classified item
  typedef struct packed {
    logic        is_byte;
    colour_e     colour;
    logic [15:0] timer;
    logic [7:0]  data;
  } cmd_t;

  typedef struct packed {
    logic checking;
    logic replying;
  } back_status_t;

  // one byte of crc-16/modbus, lsb first
  function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CrcPoly;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

### sv/tlbm_queue.sv
// short command queue between the front and back of the lamp monitor
module tlbm_queue import tlbm_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  cmd_t wdata_i,
  input  logic pop_i,
  output logic full_o,
  output logic empty_o,
  output cmd_t rdata_o
);

  cmd_t             mem_q [QDepth];
  logic [QPtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [QPtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [QCntW-1:0] cnt_q, cnt_d;

  assign full_o  = (cnt_q == QCntW'(QDepth));
  assign empty_o = (cnt_q == '0);
  assign rdata_o = mem_q[rd_ptr_q];

  // pointer and fill count update
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == QPtrW'(QDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == QPtrW'(QDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // entry storage, no reset
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

endmodule

### sv/tlbm_front.sv
// input side: takes items and picks the active lamp colour
module tlbm_front import tlbm_pkg::*; (
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [63:0] s_axis_tdata,
  input  logic        s_axis_tuser,
  input  logic [11:0] threshold_i,
  input  logic        q_full_i,
  output logic        push_o,
  output cmd_t        cmd_o
);

  logic [11:0] red_lvl, yel_lvl, grn_lvl;
  logic [11:0] best;
  colour_e     colour;

  assign red_lvl = s_axis_tdata[11:0];
  assign yel_lvl = s_axis_tdata[23:12];
  assign grn_lvl = s_axis_tdata[35:24];

  assign s_axis_tready = !q_full_i;
  assign push_o        = s_axis_tvalid && !q_full_i;

  // first strictly largest level, dark below threshold
  always_comb begin
    best   = '0;
    colour = ColNone;
    if (red_lvl > best) begin
      best   = red_lvl;
      colour = ColRed;
    end
    if (yel_lvl > best) begin
      best   = yel_lvl;
      colour = ColYellow;
    end
    if (grn_lvl > best) begin
      best   = grn_lvl;
      colour = ColGreen;
    end
    if (best < threshold_i) begin
      colour = ColNone;
    end
  end

  always_comb begin
    cmd_o.is_byte = s_axis_tuser;
    cmd_o.colour  = colour;
    cmd_o.timer   = s_axis_tdata[51:36];
    cmd_o.data    = s_axis_tdata[59:52];
  end

endmodule

### sv/tlbm_back.sv
// execution side: lamp state, request check and reply output
module tlbm_back import tlbm_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  cfg_t         cfg_i,
  input  logic         q_empty_i,
  input  cmd_t         cmd_i,
  output logic         pop_o,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [7:0]   m_axis_tdata,
  output logic         m_axis_tlast,
  output back_status_t status_o
);

  typedef enum logic [1:0] {
    SIdle,
    SCheck,
    SReply
  } state_e;

  state_e               state_q, state_d;
  logic                 blinking_q, blinking_d;
  colour_e              lit_q, lit_d;
  colour_e              shown_q, shown_d;
  colour_e              current_q, current_d;
  logic [15:0]          on_start_q, on_start_d;
  logic [15:0]          red_cnt_q, red_cnt_d;
  logic [15:0]          yel_cnt_q, yel_cnt_d;
  logic [15:0]          grn_cnt_q, grn_cnt_d;
  logic [7:0]           buf_q [ReqLen];
  logic [7:0]           buf_d [ReqLen];
  logic [ReqIdxW-1:0]   cnt_q, cnt_d;
  logic [StepW-1:0]     step_q, step_d;
  logic [ReplyIdxW-1:0] idx_q, idx_d;
  logic [15:0]          crc_q, crc_d;
  logic                 m_valid_q, m_valid_d;
  logic [7:0]           m_data_q, m_data_d;
  logic                 m_last_q, m_last_d;

  logic [7:0]  reply_byte;
  logic [7:0]  crc_in;
  logic [15:0] crc_nx;
  logic [15:0] elapsed;
  logic        out_free;
  logic        addr_bad;
  logic        crc_hit;

  assign m_axis_tvalid     = m_valid_q;
  assign m_axis_tdata      = m_data_q;
  assign m_axis_tlast      = m_last_q;
  assign status_o.checking = (state_q == SCheck);
  assign status_o.replying = (state_q == SReply);

  // reply frame byte at the current position
  always_comb begin
    case (idx_q)
      ReplyIdxW'(0):  reply_byte = cfg_i.dev_addr;
      ReplyIdxW'(1):  reply_byte = FuncCode;
      ReplyIdxW'(2):  reply_byte = ByteCount;
      ReplyIdxW'(3):  reply_byte = cfg_i.kind;
      ReplyIdxW'(4):  reply_byte = {7'b0, blinking_q};
      ReplyIdxW'(5):  reply_byte = {6'b0, current_q};
      ReplyIdxW'(6):  reply_byte = {6'b0, shown_q};
      ReplyIdxW'(7):  reply_byte = red_cnt_q[15:8];
      ReplyIdxW'(8):  reply_byte = red_cnt_q[7:0];
      ReplyIdxW'(9):  reply_byte = yel_cnt_q[15:8];
      ReplyIdxW'(10): reply_byte = yel_cnt_q[7:0];
      ReplyIdxW'(11): reply_byte = grn_cnt_q[15:8];
      ReplyIdxW'(12): reply_byte = grn_cnt_q[7:0];
      ReplyIdxW'(13): reply_byte = crc_q[7:0];
      ReplyIdxW'(14): reply_byte = crc_q[15:8];
      default:        reply_byte = 8'h00;
    endcase
  end

  // one crc unit shared by the request check and the reply
  assign crc_in  = (state_q == SCheck) ? buf_q[0] : reply_byte;
  assign crc_nx  = crc_byte(crc_q, crc_in);
  assign elapsed = cmd_i.timer - on_start_q;
  assign out_free = !m_valid_q || m_axis_tready;
  assign addr_bad = (step_q == '0) && (buf_q[0] != cfg_i.dev_addr);
  assign crc_hit  = (buf_q[1] == crc_nx[7:0]) && (buf_q[2] == crc_nx[15:8]);

  always_comb begin
    state_d    = state_q;
    blinking_d = blinking_q;
    lit_d      = lit_q;
    shown_d    = shown_q;
    current_d  = current_q;
    on_start_d = on_start_q;
    red_cnt_d  = red_cnt_q;
    yel_cnt_d  = yel_cnt_q;
    grn_cnt_d  = grn_cnt_q;
    buf_d      = buf_q;
    cnt_d      = cnt_q;
    step_d     = step_q;
    idx_d      = idx_q;
    crc_d      = crc_q;
    m_valid_d  = m_valid_q;
    m_data_d   = m_data_q;
    m_last_d   = m_last_q;
    pop_o      = 1'b0;

    // output item taken
    if (m_valid_q && m_axis_tready) begin
      m_valid_d = 1'b0;
    end

    unique case (state_q)
      SIdle: begin
        if (!q_empty_i) begin
          pop_o = 1'b1;
          if (cmd_i.is_byte) begin
            // serial byte into the request buffer
            buf_d[cnt_q] = cmd_i.data;
            if (cnt_q == ReqIdxW'(ReqLen - 1)) begin
              cnt_d   = '0;
              step_d  = '0;
              crc_d   = CrcInit;
              state_d = SCheck;
            end else begin
              cnt_d = cnt_q + 1'b1;
            end
          end else begin
            // lamp sample
            current_d = cmd_i.colour;
            if (cmd_i.colour != ColNone) begin
              if (lit_q == ColNone) begin
                lit_d      = cmd_i.colour;
                on_start_d = cmd_i.timer;
              end else if (elapsed > cfg_i.window) begin
                blinking_d = 1'b0;
              end
              shown_d = cmd_i.colour;
            end else begin
              if (elapsed < cfg_i.window) begin
                blinking_d = 1'b1;
                case (lit_q)
                  ColRed:    red_cnt_d = red_cnt_q + 1'b1;
                  ColYellow: yel_cnt_d = yel_cnt_q + 1'b1;
                  ColGreen:  grn_cnt_d = grn_cnt_q + 1'b1;
                  default:   ;
                endcase
              end
              lit_d = ColNone;
            end
          end
        end
      end

      SCheck: begin
        // one prefix a cycle, buffer shifts down so the taps stay fixed
        if (!addr_bad && crc_hit) begin
          for (int k = 0; k < ReqLen; k++) begin
            buf_d[k] = 8'h00;
          end
          idx_d   = '0;
          crc_d   = CrcInit;
          state_d = SReply;
        end else if (addr_bad || step_q == StepW'(ReqSteps - 1)) begin
          for (int k = 0; k < ReqLen; k++) begin
            buf_d[k] = 8'h00;
          end
          state_d = SIdle;
        end else begin
          for (int k = 0; k < ReqLen - 1; k++) begin
            buf_d[k] = buf_q[k+1];
          end
          buf_d[ReqLen-1] = 8'h00;
          crc_d  = crc_nx;
          step_d = step_q + 1'b1;
        end
      end

      SReply: begin
        // one frame byte into the output register when it frees up
        if (out_free) begin
          m_valid_d = 1'b1;
          m_data_d  = reply_byte;
          m_last_d  = (idx_q == ReplyIdxW'(ReplyLen - 1));
          if (idx_q < ReplyIdxW'(ReplyCrcPos)) begin
            crc_d = crc_nx;
          end
          if (idx_q == ReplyIdxW'(ReplyLen - 1)) begin
            state_d = SIdle;
          end else begin
            idx_d = idx_q + 1'b1;
          end
        end
      end

      default: begin
        state_d = SIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= SIdle;
      blinking_q <= 1'b0;
      lit_q      <= ColNone;
      shown_q    <= ColNone;
      current_q  <= ColNone;
      on_start_q <= '0;
      red_cnt_q  <= '0;
      yel_cnt_q  <= '0;
      grn_cnt_q  <= '0;
      for (int k = 0; k < ReqLen; k++) begin
        buf_q[k] <= 8'h00;
      end
      cnt_q      <= '0;
      step_q     <= '0;
      idx_q      <= '0;
      crc_q      <= CrcInit;
      m_valid_q  <= 1'b0;
      m_data_q   <= 8'h00;
      m_last_q   <= 1'b0;
    end else begin
      state_q    <= state_d;
      blinking_q <= blinking_d;
      lit_q      <= lit_d;
      shown_q    <= shown_d;
      current_q  <= current_d;
      on_start_q <= on_start_d;
      red_cnt_q  <= red_cnt_d;
      yel_cnt_q  <= yel_cnt_d;
      grn_cnt_q  <= grn_cnt_d;
      buf_q      <= buf_d;
      cnt_q      <= cnt_d;
      step_q     <= step_d;
      idx_q      <= idx_d;
      crc_q      <= crc_d;
      m_valid_q  <= m_valid_d;
      m_data_q   <= m_data_d;
      m_last_q   <= m_last_d;
    end
  end

endmodule

### sv/tower_lamp_blink_monitor_modbus.sv
// top level of the tower lamp blink monitor with status reply
//
//  channel   dir  handshake                      payload
//  s_axis    in   s_axis_tvalid/s_axis_tready    tdata: levels, timer, rx byte; tuser: kind
//  m_axis    out  m_axis_tvalid/m_axis_tready    tdata: tx byte; tlast: last frame byte
//  cfg       in   cfg_we_i (no wait)             cfg_idx_i, cfg_data_i
//
// a lamp sample or a non-final serial byte is popped and absorbed in the back end's idle state
// the sixth request byte starts a crc check of up to four prefixes, one prefix per check step
// a valid request then emits 15 reply bytes, one per cycle at best, paced by m_axis_tready
// a two-entry command queue and the output register let input and output stall apart
// reset clears all state at once but the queue entry storage; no clearing pass
`include "tower_lamp_blink_monitor_modbus_defines.svh"

module tower_lamp_blink_monitor_modbus import tlbm_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // red_level[11:0], yellow_level[23:12], green_level[35:24], timer_now[51:36],
  // rx_byte[59:52], zero fill[63:60]
  input  logic [63:0] s_axis_tdata,
  // operation[0]
  input  logic        s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // tx_byte[7:0]
  output logic [7:0]  m_axis_tdata,
  output logic        m_axis_tlast,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [15:0] cfg_data_i
);

  cfg_t         cfg_q;
  logic         q_full;
  logic         q_empty;
  logic         push;
  logic         pop;
  cmd_t         cmd_in;
  cmd_t         cmd_head;
  back_status_t back_st;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.dev_addr  <= 8'd1;
      cfg_q.threshold <= 12'd2000;
      cfg_q.window    <= 16'd500;
      cfg_q.kind      <= 8'd1;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CfgDevAddr:   cfg_q.dev_addr  <= cfg_data_i[7:0];
        CfgThreshold: cfg_q.threshold <= cfg_data_i[11:0];
        CfgWindow:    cfg_q.window    <= cfg_data_i;
        CfgKind:      cfg_q.kind      <= cfg_data_i[7:0];
        default:      ;
      endcase
    end
  end

  tlbm_front u_front (
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .threshold_i   (cfg_q.threshold),
    .q_full_i      (q_full),
    .push_o        (push),
    .cmd_o         (cmd_in)
  );

  tlbm_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .wdata_i (cmd_in),
    .pop_i   (pop),
    .full_o  (q_full),
    .empty_o (q_empty),
    .rdata_o (cmd_head)
  );

  tlbm_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (cfg_q),
    .q_empty_i     (q_empty),
    .cmd_i         (cmd_head),
    .pop_o         (pop),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .status_o      (back_st)
  );

  // an accepted item is waiting in the queue next cycle
  `TLBM_ASSERT_NXT(a_push_fills, s_axis_tvalid && s_axis_tready, !q_empty)
  // a stalled output item keeps its data until taken
  `TLBM_ASSERT_NXT(a_out_hold, m_axis_tvalid && !m_axis_tready,
                   m_axis_tvalid && $stable({m_axis_tdata, m_axis_tlast}))
  // a stalled output holds the reply sequencer in place
  `TLBM_ASSERT_NXT(a_reply_holds, back_st.replying && m_axis_tvalid && !m_axis_tready,
                   back_st.replying)
  // no queue pops while checking or replying
  `TLBM_ASSERT_IMP(a_pop_idle, pop, !back_st.checking && !back_st.replying)

endmodule

### tb/testbench.sv
// self-checking testbench of the tower lamp blink monitor with status reply
module testbench;
  import tlbm_pkg::*;

  localparam int IdleLimit     = 2000;
  localparam int SettleCycles  = 40;
  localparam int HoldCycles    = 300;
  localparam int MaxGap        = 17;
  localparam int ItemsPerPhase = 38;
  localparam int ResetCycles   = 12;

  typedef enum {RowSample, RowByte, RowRequest} row_kind_e;
  typedef enum {ReplyByModel, ReplyNone} reply_check_e;

  typedef struct {
    row_kind_e    kind;
    reply_check_e reply;
    logic [11:0]  lvl_r;
    logic [11:0]  lvl_y;
    logic [11:0]  lvl_g;
    logic [15:0]  tick;
    logic [7:0]   byte_val;
    int           prefix;
    bit           corrupt;
  } directed_row_t;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } reply_byte_t;

  // dut ports
  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [63:0] s_axis_tdata  = '0;
  logic        s_axis_tuser  = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [7:0]  m_axis_tdata;
  logic        m_axis_tlast;
  logic        cfg_we_i      = 1'b0;
  logic [1:0]  cfg_idx_i     = '0;
  logic [15:0] cfg_data_i    = '0;

  // register copies
  logic [7:0]  cfg_addr = 8'd1;
  logic [11:0] cfg_thr  = 12'd2000;
  logic [15:0] cfg_win  = 16'd500;
  logic [7:0]  cfg_kind = 8'd1;

  // lamp and request state as the block should hold it
  logic        blink_flag = 1'b0;
  colour_e     lit_col    = ColNone;
  colour_e     shown_col  = ColNone;
  colour_e     cur_col    = ColNone;
  logic [15:0] on_since   = '0;
  logic [15:0] blink_cnt [3] = '{default: 16'd0};
  logic [7:0]  req_buf [ReqLen] = '{default: 8'd0};
  int          req_fill = 0;

  reply_byte_t pending_reply_q [$];

  int          fail_count    = 0;
  int          items_offered = 0;
  int          idle_cycles   = 0;
  int          hold_asked    = 0;
  int          hold_given    = 0;
  bit          sender_no_idle = 1'b0;
  bit          sink_no_idle   = 1'b0;
  logic [15:0] sample_clock  = '0;

  // lamp extremes, colour picking, blink timing and request checks
  directed_row_t directed_rows [17] = '{
    '{RowRequest, ReplyByModel, 12'd0,    12'd0,    12'd0,    16'd0,     8'h01, 1, 1'b0},
    '{RowRequest, ReplyNone,    12'd0,    12'd0,    12'd0,    16'd0,     8'h02, 2, 1'b0},
    '{RowSample,  ReplyByModel, 12'd0,    12'd0,    12'd0,    16'd0,     8'h00, 0, 1'b0},
    '{RowSample,  ReplyByModel, 12'd4095, 12'd4095, 12'd4095, 16'd100,   8'h00, 0, 1'b0},
    '{RowSample,  ReplyByModel, 12'd0,    12'd0,    12'd0,    16'd200,   8'h00, 0, 1'b0},
    '{RowSample,  ReplyByModel, 12'd2000, 12'd1999, 12'd0,    16'd300,   8'h00, 0, 1'b0},
    '{RowSample,  ReplyByModel, 12'd1999, 12'd0,    12'd1999, 16'd350,   8'h00, 0, 1'b0},
    '{RowSample,  ReplyByModel, 12'd100,  12'd3000, 12'd3000, 16'd400,   8'h00, 0, 1'b0},
    '{RowSample,  ReplyByModel, 12'd0,    12'd0,    12'd4095, 16'd500,   8'h00, 0, 1'b0},
    '{RowSample,  ReplyByModel, 12'd0,    12'd0,    12'd0,    16'd550,   8'h00, 0, 1'b0},
    '{RowSample,  ReplyByModel, 12'd0,    12'd0,    12'd4000, 16'd65500, 8'h00, 0, 1'b0},
    '{RowSample,  ReplyByModel, 12'd0,    12'd0,    12'd0,    16'd10,    8'h00, 0, 1'b0},
    '{RowSample,  ReplyByModel, 12'd3000, 12'd0,    12'd0,    16'd1000,  8'h00, 0, 1'b0},
    '{RowSample,  ReplyByModel, 12'd3000, 12'd0,    12'd0,    16'd1500,  8'h00, 0, 1'b0},
    '{RowSample,  ReplyByModel, 12'd3000, 12'd0,    12'd0,    16'd1501,  8'h00, 0, 1'b0},
    '{RowSample,  ReplyByModel, 12'd0,    12'd0,    12'd0,    16'd1500,  8'h00, 0, 1'b0},
    '{RowRequest, ReplyByModel, 12'd0,    12'd0,    12'd0,    16'd0,     8'h01, 4, 1'b0}
  };

  tower_lamp_blink_monitor_modbus u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // crc-16/modbus over one byte, lsb first
  function automatic logic [15:0] crc16_modbus_byte(input logic [15:0] acc,
                                                    input logic [7:0] b);
    logic [15:0] c;
    c = acc ^ {8'h00, b};
    repeat (8) c = c[0] ? ((c >> 1) ^ CrcPoly) : (c >> 1);
    return c;
  endfunction

  // active colour, on-time start, blink flag and blink counts
  task automatic update_lamp_state(input logic [11:0] r, input logic [11:0] y,
                                   input logic [11:0] g, input logic [15:0] t);
    logic [11:0] best;
    colour_e     col;
    logic [15:0] dt;
    best = '0;
    col  = ColNone;
    if (r > best) begin
      best = r;
      col  = ColRed;
    end
    if (y > best) begin
      best = y;
      col  = ColYellow;
    end
    if (g > best) begin
      best = g;
      col  = ColGreen;
    end
    if (best < cfg_thr) col = ColNone;
    cur_col = col;
    if (col != ColNone) begin
      if (lit_col == ColNone) begin
        lit_col  = col;
        on_since = t;
      end
      dt = t - on_since;
      if (dt > cfg_win) blink_flag = 1'b0;
      shown_col = col;
    end else begin
      dt = t - on_since;
      if (dt < cfg_win) begin
        blink_flag = 1'b1;
        if (lit_col != ColNone) blink_cnt[int'(lit_col) - 1] += 16'd1;
      end
      lit_col = ColNone;
    end
  endtask

  // request buffer fill, address and crc check, status frame
  task automatic absorb_rx_byte(input logic [7:0] b, input bit keep);
    logic [15:0] acc;
    logic        ok;
    logic [7:0]  f [ReplyLen];
    req_buf[req_fill] = b;
    req_fill++;
    if (req_fill == ReqLen) begin
      ok  = 1'b0;
      acc = CrcInit;
      if (req_buf[0] == cfg_addr) begin
        for (int i = 0; i + 2 < ReqLen; i++) begin
          acc = crc16_modbus_byte(acc, req_buf[i]);
          if (req_buf[i + 1] == acc[7:0] && req_buf[i + 2] == acc[15:8]) ok = 1'b1;
        end
      end
      if (ok && keep) begin
        f[0]  = cfg_addr;
        f[1]  = FuncCode;
        f[2]  = ByteCount;
        f[3]  = cfg_kind;
        f[4]  = {7'd0, blink_flag};
        f[5]  = {6'd0, cur_col};
        f[6]  = {6'd0, shown_col};
        f[7]  = blink_cnt[0][15:8];
        f[8]  = blink_cnt[0][7:0];
        f[9]  = blink_cnt[1][15:8];
        f[10] = blink_cnt[1][7:0];
        f[11] = blink_cnt[2][15:8];
        f[12] = blink_cnt[2][7:0];
        acc = CrcInit;
        for (int i = 0; i < ReplyCrcPos; i++) acc = crc16_modbus_byte(acc, f[i]);
        f[ReplyCrcPos]     = acc[7:0];
        f[ReplyCrcPos + 1] = acc[15:8];
        for (int i = 0; i < ReplyLen; i++) begin
          pending_reply_q.push_back('{data: f[i], last: (i == ReplyLen - 1)});
        end
      end
      req_buf  = '{default: 8'd0};
      req_fill = 0;
    end
  endtask

  // offer one item after a random gap, track it once accepted
  task automatic offer_item(input logic op, input logic [11:0] r, input logic [11:0] y,
                            input logic [11:0] g, input logic [15:0] t,
                            input logic [7:0] rx, input bit keep);
    int gap;
    gap = sender_no_idle ? 0 : $urandom_range(0, MaxGap);
    repeat (gap) @(negedge clk_i) s_axis_tvalid <= 1'b0;
    @(negedge clk_i);
    s_axis_tuser  <= op;
    s_axis_tdata  <= {4'h0, rx, t, g, y, r};
    s_axis_tvalid <= 1'b1;
    do @(posedge clk_i); while (!s_axis_tready);
    items_offered++;
    if (op) absorb_rx_byte(rx, keep);
    else update_lamp_state(r, y, g, t);
  endtask

  // six request bytes, padded first so the frame lines up with the buffer
  task automatic send_request(input logic [7:0] addr, input int prefix, input bit corrupt,
                              input bit keep);
    logic [7:0]  b [ReqLen];
    logic [15:0] acc;
    int          pos;
    while (req_fill != 0) begin
      offer_item(1'b1, 12'($urandom_range(0, 4095)), 12'($urandom_range(0, 4095)),
                 12'($urandom_range(0, 4095)), 16'($urandom_range(0, 65535)),
                 8'($urandom_range(0, 255)), 1'b1);
    end
    b[0] = addr;
    for (int i = 1; i < ReqLen; i++) b[i] = 8'($urandom_range(0, 255));
    acc = CrcInit;
    for (int i = 0; i < prefix; i++) acc = crc16_modbus_byte(acc, b[i]);
    b[prefix]     = acc[7:0];
    b[prefix + 1] = acc[15:8];
    if (corrupt) begin
      pos = $urandom_range(1, ReqLen - 1);
      b[pos] ^= 8'h01 << $urandom_range(0, 7);
    end
    for (int i = 0; i < ReqLen; i++) begin
      offer_item(1'b1, 12'($urandom_range(0, 4095)), 12'($urandom_range(0, 4095)),
                 12'($urandom_range(0, 4095)), 16'($urandom_range(0, 65535)), b[i], keep);
    end
  endtask

  // lamp reading: mostly dark or one dominant lamp, timer steps around the window
  task automatic offer_lamp_reading();
    logic [11:0] lv [3];
    int          pick;
    int          dice;
    logic [15:0] step;
    dice = $urandom_range(0, 99);
    if (dice < 15) begin
      foreach (lv[k]) lv[k] = 12'($urandom_range(0, 4095));
    end else if (dice < 45) begin
      foreach (lv[k]) lv[k] = (cfg_thr == 0) ? 12'd0 : 12'($urandom_range(0, cfg_thr - 1));
    end else begin
      pick = $urandom_range(0, 2);
      lv[pick] = 12'($urandom_range(cfg_thr, 4095));
      foreach (lv[k]) if (k != pick) lv[k] = 12'($urandom_range(0, lv[pick]));
    end
    dice = $urandom_range(0, 99);
    if (dice < 50) step = 16'($urandom_range(0, 700));
    else if (dice < 70) step = cfg_win + 16'($urandom_range(0, 2)) - 16'd1;
    else if (dice < 85) step = 16'($urandom_range(0, 65535));
    else step = '0;
    sample_clock += step;
    offer_item(1'b0, lv[0], lv[1], lv[2], sample_clock, 8'($urandom_range(0, 255)), 1'b1);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
    @(negedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      CfgDevAddr:   cfg_addr = val[7:0];
      CfgThreshold: cfg_thr  = val[11:0];
      CfgWindow:    cfg_win  = val;
      CfgKind:      cfg_kind = val[7:0];
      default: ;
    endcase
  endtask

  // stop offering, let every reply arrive and the back end settle
  task automatic wait_drained();
    @(negedge clk_i) s_axis_tvalid <= 1'b0;
    while (pending_reply_q.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  // one register setting followed by a random mix of items
  task automatic run_phase(input logic [7:0] addr, input logic [11:0] thr,
                           input logic [15:0] win, input logic [7:0] kind,
                           input bit fast_src, input bit fast_sink, input bit hold);
    int first;
    int dice;
    wait_drained();
    // junk in the unused upper bits must be dropped
    write_reg(CfgDevAddr, {8'($urandom_range(0, 255)), addr});
    write_reg(CfgThreshold, {4'($urandom_range(0, 15)), thr});
    write_reg(CfgWindow, win);
    write_reg(CfgKind, {8'($urandom_range(0, 255)), kind});
    sender_no_idle = fast_src;
    sink_no_idle   = fast_sink;
    first = items_offered;
    if (hold) begin
      hold_asked++;
      send_request(cfg_addr, 1, 1'b0, 1'b1);
    end
    while (items_offered - first < ItemsPerPhase) begin
      dice = $urandom_range(0, 99);
      if (dice < 45) offer_lamp_reading();
      else if (dice < 75) send_request(cfg_addr, $urandom_range(1, ReqLen - 2), 1'b0, 1'b1);
      else if (dice < 80) send_request(cfg_addr + 8'd1, $urandom_range(1, ReqLen - 2), 1'b0,
                                       1'b1);
      else if (dice < 88) send_request(cfg_addr, $urandom_range(1, ReqLen - 2), 1'b1, 1'b1);
      else offer_item(1'b1, 12'($urandom_range(0, 4095)), 12'($urandom_range(0, 4095)),
                      12'($urandom_range(0, 4095)), 16'($urandom_range(0, 65535)),
                      8'($urandom_range(0, 255)), 1'b1);
    end
  endtask

  // reply sink: random stalls, one long hold-off on request
  initial begin
    int gap;
    m_axis_tready = 1'b0;
    @(posedge rst_ni);
    forever begin
      if (hold_given != hold_asked) begin
        hold_given = hold_asked;
        repeat (HoldCycles) @(negedge clk_i) m_axis_tready <= 1'b0;
      end
      gap = sink_no_idle ? 0 : $urandom_range(0, MaxGap);
      repeat (gap) @(negedge clk_i) m_axis_tready <= 1'b0;
      @(negedge clk_i) m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (!(m_axis_tvalid && m_axis_tready));
    end
  end

  // compare each reply item with the oldest expected one
  always @(posedge clk_i) begin
    reply_byte_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pending_reply_q.size() == 0) begin
        $error("reply item with none expected: tx_byte %02h frame_last %0b",
               m_axis_tdata, m_axis_tlast);
        fail_count++;
      end else begin
        want = pending_reply_q.pop_front();
        if (m_axis_tdata !== want.data) begin
          $error("tx_byte mismatch: expected %02h, actual %02h", want.data, m_axis_tdata);
          fail_count++;
        end
        if (m_axis_tlast !== want.last) begin
          $error("frame_last mismatch: expected %0b, actual %0b", want.last, m_axis_tlast);
          fail_count++;
        end
      end
    end
  end

  // watchdog on cycles with no item moving on either side
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= IdleLimit) begin
        $display("*** FAILED ***");
        $finish;
      end
    end
  end

  // main sequence
  initial begin
    directed_row_t row;
    repeat (ResetCycles) @(negedge clk_i);
    rst_ni <= 1'b1;

    foreach (directed_rows[n]) begin
      row = directed_rows[n];
      case (row.kind)
        RowSample: begin
          offer_item(1'b0, row.lvl_r, row.lvl_y, row.lvl_g, row.tick,
                     8'($urandom_range(0, 255)), 1'b1);
        end
        RowByte: begin
          offer_item(1'b1, 12'($urandom_range(0, 4095)), 12'($urandom_range(0, 4095)),
                     12'($urandom_range(0, 4095)), 16'($urandom_range(0, 65535)),
                     row.byte_val, row.reply == ReplyByModel);
        end
        default: begin
          send_request(row.byte_val, row.prefix, row.corrupt, row.reply == ReplyByModel);
        end
      endcase
    end

    run_phase(8'h00, 12'd0, 16'd0, 8'h00, 1'b0, 1'b0, 1'b0);
    run_phase(8'hFF, 12'd4095, 16'hFFFF, 8'hFF, 1'b1, 1'b1, 1'b0);
    run_phase(8'h01, 12'd2000, 16'd500, 8'h01, 1'b1, 1'b0, 1'b1);
    run_phase(8'($urandom_range(0, 255)), 12'($urandom_range(500, 3000)),
              16'($urandom_range(50, 1500)), 8'($urandom_range(0, 255)), 1'b0, 1'b0, 1'b0);
    run_phase(8'($urandom_range(0, 255)), 12'($urandom_range(0, 4095)),
              16'($urandom_range(0, 65535)), 8'($urandom_range(0, 255)), 1'b0, 1'b1, 1'b0);
    run_phase(8'h5A, 12'd1, 16'd1, 8'hA5, 1'b0, 1'b0, 1'b0);

    wait_drained();
    if (fail_count == 0 && pending_reply_q.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

### tower_lamp_blink_monitor_modbus.f
+incdir+sv
sv/tlbm_pkg.sv
sv/tlbm_queue.sv
sv/tlbm_front.sv
sv/tlbm_back.sv
sv/tower_lamp_blink_monitor_modbus.sv
tb/testbench.sv
